// ----- hw/rtl/float_divide_sqrt_srt_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the divide / square root unit
// Clocked assertion shorthands; the asserting module supplies clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef FLOAT_DIVIDE_SQRT_SRT_UNIT_MACROS_SVH
`define FLOAT_DIVIDE_SQRT_SRT_UNIT_MACROS_SVH

// Checked only outside reset.
`define DSQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DSQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/dsq_pkg.sv -----
// ----------------------------------------------------------------------------
// dsq_pkg
// Types, constants and digit selection shared by the divide / root pipeline.
// ----------------------------------------------------------------------------
package dsq_pkg;

	localparam int unsigned SRT_STEPS = 25;

	localparam logic [31:0] EXP_FIELD  = 32'h7F80_0000;
	localparam logic [31:0] FRAC_FIELD = 32'h007F_FFFF;
	localparam logic [31:0] HIDDEN_ONE = 32'h0080_0000;
	localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
	localparam logic [31:0] MAX_MAG    = 32'h7FFF_FFFF;
	localparam logic [31:0] EST_LOW    = 32'h00FF_FFFF;
	localparam logic [31:0] EST_POS    = 32'h0080_0000;
	localparam logic [31:0] EST_NEG    = 32'hFF00_0000;
	localparam logic [31:0] NORM_LIMIT = 32'h0100_0000;

	localparam logic signed [9:0] DIV_BIAS  = 10'sd126;
	localparam logic [8:0]        ROOT_BIAS = 9'd127;

	// Flag positions in a flag vector
	localparam int unsigned FLG_INVALID   = 0;
	localparam int unsigned FLG_DIV_ZERO  = 1;
	localparam int unsigned FLG_OVERFLOW  = 2;
	localparam int unsigned FLG_UNDERFLOW = 3;

	localparam logic MODE_DIV  = 1'b0;
	localparam logic MODE_ROOT = 1'b1;

	typedef enum logic [1:0] {
		DIG_ZERO = 2'b00,
		DIG_POS  = 2'b01,
		DIG_NEG  = 2'b10
	} digit_t;

	// Recurrence state carried down the pipe
	typedef struct packed {
		logic [31:0] rs;
		logic [31:0] rc;
		logic [31:0] q;
		digit_t      dig;
		logic [23:0] dmant;
	} srt_t;

	// Side information that rides along with each transaction
	typedef struct packed {
		logic               mode;
		logic               bypass;
		logic               sign;
		logic signed [9:0]  expo;
		logic [31:0]        byp_word;
		logic [3:0]         byp_flags;
	} meta_t;

	// Select the next digit from a truncated estimate of the carry-save remainder.
	function automatic digit_t pick_digit(input logic [31:0] s, input logic [31:0] c);
		logic [31:0] est;
		digit_t      d;
		est = ((s & ~EST_LOW) + c) | (s & EST_LOW);
		d   = DIG_ZERO;
		if (!est[31] && (est >= EST_POS))
			d = DIG_POS;
		else if (est[31] && (est < EST_NEG))
			d = DIG_NEG;
		return d;
	endfunction

endpackage

// ----- hw/rtl/float_divide_sqrt_srt_unit.sv -----
// ----------------------------------------------------------------------------
// float_divide_sqrt_srt_unit
// Pipelined divide and square root for a 32-bit float format without
// infinities or NaNs. One transaction enters per cycle while the pipe is not
// frozen. Its result passes one register stage for operand unpacking, one for
// each of the 25 radix-2 SRT iterations, and one for normalization and packing
// into the output register. The whole pipe freezes only while a valid result
// sits in the output register with out_stall high, so in_stall follows that
// condition and a stalled result never blocks new transactions otherwise.
// ----------------------------------------------------------------------------
`include "float_divide_sqrt_srt_unit_macros.svh"

module float_divide_sqrt_srt_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_word,
	output logic        flag_invalid,
	output logic        flag_div_zero,
	output logic        flag_overflow,
	output logic        flag_underflow
);
	import dsq_pkg::*;

	logic  en;
	logic  stg_valid [SRT_STEPS+1];
	srt_t  stg_srt   [SRT_STEPS+1];
	meta_t stg_meta  [SRT_STEPS+1];

	// advance everything unless the output register is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	dsq_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.mode      (mode),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.valid_s1  (stg_valid[0]),
		.srt_s1    (stg_srt[0]),
		.meta_s1   (stg_meta[0])
	);

	for (genvar k = 0; k < SRT_STEPS; k++) begin : g_step
		dsq_srt_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.step_idx (5'(k)),
			.in_valid (stg_valid[k]),
			.srt_in   (stg_srt[k]),
			.meta_in  (stg_meta[k]),
			.valid_s1 (stg_valid[k+1]),
			.srt_s1   (stg_srt[k+1]),
			.meta_s1  (stg_meta[k+1])
		);
	end

	dsq_post u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (stg_valid[SRT_STEPS]),
		.srt_in         (stg_srt[SRT_STEPS]),
		.meta_in        (stg_meta[SRT_STEPS]),
		.out_valid      (out_valid),
		.result_word    (result_word),
		.flag_invalid   (flag_invalid),
		.flag_div_zero  (flag_div_zero),
		.flag_overflow  (flag_overflow),
		.flag_underflow (flag_underflow)
	);

	`DSQ_ASSERT(a_one_flag,
		out_valid |-> $onehot0({flag_invalid, flag_div_zero, flag_overflow, flag_underflow}),
		"more than one exception flag raised")
	`DSQ_ASSERT(a_ovf_clamp,
		(out_valid && flag_overflow) |-> (result_word[30:0] == 31'h7FFF_FFFF),
		"overflow result not clamped to maximum magnitude")
	`DSQ_ASSERT(a_unf_zero,
		(out_valid && flag_underflow) |-> (result_word[30:0] == 31'd0),
		"underflow result not forced to zero")
	`DSQ_ASSERT(a_hold_freeze,
		(out_valid && out_stall) |=> (out_valid && $stable(result_word)),
		"held result changed while the pipe was frozen")
	`DSQ_ASSERT_ALWAYS(a_rst_empty, !arst_n |=> !out_valid, "result valid during reset")

endmodule

// ----- hw/rtl/dsq_prep.sv -----
// ----------------------------------------------------------------------------
// dsq_prep
// Unpacks the operands, resolves zero operands and seeds the recurrence.
// ----------------------------------------------------------------------------
module dsq_prep (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic           mode,
	input  logic [31:0]    operand_a,
	input  logic [31:0]    operand_b,
	output logic           valid_s1,
	output dsq_pkg::srt_t  srt_s1,
	output dsq_pkg::meta_t meta_s1
);
	import dsq_pkg::*;

	srt_t  srt_d;
	meta_t meta_d;

	always_comb begin
		logic        sgn;
		logic        az;
		logic        bz;
		logic [23:0] mant_a;
		logic [8:0]  root_e;
		sgn    = operand_a[31] ^ operand_b[31];
		az     = (operand_a & EXP_FIELD) == 32'd0;
		bz     = (operand_b & EXP_FIELD) == 32'd0;
		mant_a = {1'b1, operand_a[22:0]};
		root_e = ({1'b0, operand_a[30:23]} + ROOT_BIAS) >> 1;

		srt_d.rc    = 32'd0;
		srt_d.q     = 32'd0;
		srt_d.dig   = DIG_POS;
		srt_d.dmant = {1'b1, operand_b[22:0]};

		meta_d.mode      = mode;
		meta_d.bypass    = 1'b0;
		meta_d.sign      = 1'b0;
		meta_d.expo      = 10'sd0;
		meta_d.byp_word  = 32'd0;
		meta_d.byp_flags = 4'd0;

		if (mode == MODE_ROOT) begin
			// shift the mantissa one more bit left for an even exponent so the root exponent halves cleanly
			srt_d.rs = operand_a[23] ? {7'd0, mant_a, 1'b0} : {6'd0, mant_a, 2'b00};
			meta_d.expo = $signed({2'b00, root_e[7:0]});
			meta_d.byp_flags[FLG_INVALID] = operand_a[31];
			meta_d.bypass = az;
		end else begin
			srt_d.rs = {6'd0, mant_a, 2'b00};
			meta_d.sign = sgn;
			meta_d.expo = $signed({2'b00, operand_a[30:23]}) - $signed({2'b00, operand_b[30:23]})
				+ DIV_BIAS;
			if (az || bz) begin
				meta_d.bypass   = 1'b1;
				meta_d.byp_word = (az && !bz) ? (sgn ? SIGN_BIT : 32'd0)
					: ((sgn ? SIGN_BIT : 32'd0) | MAX_MAG);
				meta_d.byp_flags[FLG_DIV_ZERO] = !az && bz;
				meta_d.byp_flags[FLG_INVALID]  = az && bz;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srt_s1  <= srt_d;
			meta_s1 <= meta_d;
		end
	end

endmodule

// ----- hw/rtl/dsq_srt_step.sv -----
// ----------------------------------------------------------------------------
// dsq_srt_step
// One radix-2 SRT iteration on a carry-save remainder, registered.
// ----------------------------------------------------------------------------
module dsq_srt_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [4:0]     step_idx,
	input  logic           in_valid,
	input  dsq_pkg::srt_t  srt_in,
	input  dsq_pkg::meta_t meta_in,
	output logic           valid_s1,
	output dsq_pkg::srt_t  srt_s1,
	output dsq_pkg::meta_t meta_s1
);
	import dsq_pkg::*;

	srt_t srt_d;

	always_comb begin
		logic [31:0] w;
		logic [31:0] part;
		logic [31:0] qdig;
		logic [31:0] v;
		logic [31:0] addend;
		logic [31:0] rc_in;
		logic [31:0] p;
		logic [31:0] ns;
		logic [31:0] nc;
		w = 32'd1 << (5'd24 - step_idx);
		case (srt_in.dig)
			DIG_POS: begin
				part   = w;
				qdig   = 32'd1;
			end
			DIG_NEG: begin
				part   = 32'd0 - w;
				qdig   = 32'hFFFF_FFFF;
			end
			default: begin
				part   = 32'd0;
				qdig   = 32'd0;
			end
		endcase

		if (meta_in.mode == MODE_ROOT) begin
			v         = srt_in.q + part;
			srt_d.q   = srt_in.q + (part << 1);
		end else begin
			v         = {6'd0, srt_in.dmant, 2'b00};
			srt_d.q   = (srt_in.q << 1) + qdig;
		end

		case (srt_in.dig)
			DIG_POS: addend = ~v;
			DIG_NEG: addend = v;
			default: addend = 32'd0;
		endcase

		// low bits of rc are always clear, so the subtract's +1 is an OR
		rc_in = (srt_in.dig == DIG_POS) ? {srt_in.rc[31:1], 1'b1} : srt_in.rc;

		p  = srt_in.rs ^ rc_in;
		ns = p ^ addend;
		nc = ((srt_in.rs & rc_in) | (p & addend)) << 1;

		srt_d.dig   = (srt_in.dig != DIG_ZERO) ? pick_digit(ns, nc)
			: pick_digit(srt_in.rs, srt_in.rc);
		srt_d.rs    = ns << 1;
		srt_d.rc    = nc << 1;
		srt_d.dmant = srt_in.dmant;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srt_s1  <= srt_d;
			meta_s1 <= meta_in;
		end
	end

endmodule

// ----- hw/rtl/dsq_post.sv -----
// ----------------------------------------------------------------------------
// dsq_post
// Normalizes and range-checks a divide quotient, then packs the result.
// ----------------------------------------------------------------------------
module dsq_post (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  dsq_pkg::srt_t  srt_in,
	input  dsq_pkg::meta_t meta_in,
	output logic           out_valid,
	output logic [31:0]    result_word,
	output logic           flag_invalid,
	output logic           flag_div_zero,
	output logic           flag_overflow,
	output logic           flag_underflow
);
	import dsq_pkg::*;

	logic [31:0] word_d;
	logic [3:0]  flags_d;

	always_comb begin
		logic signed [10:0] ex;
		logic [31:0]        qn;
		logic [31:0]        sgn;
		sgn = meta_in.sign ? SIGN_BIT : 32'd0;
		ex  = 11'(meta_in.expo);
		qn  = srt_in.q;
		if (srt_in.q >= NORM_LIMIT) begin
			ex = ex + 11'sd1;
			qn = srt_in.q >> 1;
		end

		word_d  = meta_in.byp_word;
		flags_d = meta_in.byp_flags;
		if (!meta_in.bypass) begin
			if (meta_in.mode == MODE_ROOT) begin
				word_d = ((srt_in.q >> 2) & FRAC_FIELD) | {1'b0, meta_in.expo[7:0], 23'd0};
			end else if (ex > 11'sd255) begin
				word_d = sgn | MAX_MAG;
				flags_d[FLG_OVERFLOW] = 1'b1;
			end else if (ex < 11'sd1) begin
				word_d = sgn;
				flags_d[FLG_UNDERFLOW] = 1'b1;
			end else begin
				word_d = (qn & FRAC_FIELD) | {1'b0, ex[7:0], 23'd0} | sgn;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_word    <= word_d;
			flag_invalid   <= flags_d[FLG_INVALID];
			flag_div_zero  <= flags_d[FLG_DIV_ZERO];
			flag_overflow  <= flags_d[FLG_OVERFLOW];
			flag_underflow <= flags_d[FLG_UNDERFLOW];
		end
	end

endmodule
